// ----- design/mavg_pkg.sv -----
// Shared constants and types for the moving average min/max block.
package mavg_pkg;

  localparam int unsigned SAMPLE_W   = 9;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned SUM_W      = 19;
  localparam int unsigned MAX_WINDOW = 1024;
  localparam int unsigned PTR_W      = $clog2(MAX_WINDOW);
  localparam int unsigned DIV_CNT_W  = $clog2(SUM_W);

  localparam logic signed [SAMPLE_W-1:0] TEMP_LOW  = -9'sd200;
  localparam logic signed [SAMPLE_W-1:0] TEMP_HIGH = 9'sd200;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_DIV_MIN,
    ST_DIV_MAX,
    ST_DONE
  } state_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

endpackage

// ----- design/mavg_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module mavg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/mavg_div.sv -----
// Iterative signed-by-unsigned restoring divider, one quotient bit per cycle.
module mavg_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  mavg_pkg::sum_t                      dividend_i,
  input  logic [mavg_pkg::LEN_W-1:0]          divisor_i,
  output logic                                done_o,
  output mavg_pkg::sample_t                   quotient_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [mavg_pkg::DIV_CNT_W-1:0]      cnt_q, cnt_d;
  logic [mavg_pkg::SUM_W-1:0]          dvd_q, dvd_d;
  logic [mavg_pkg::SUM_W-1:0]          quo_q, quo_d;
  logic [mavg_pkg::LEN_W-1:0]          rem_q, rem_d;
  logic [mavg_pkg::LEN_W-1:0]          dvs_q, dvs_d;
  logic                                neg_q, neg_d;
  logic [mavg_pkg::LEN_W:0]            trial;
  logic [mavg_pkg::LEN_W:0]            diff;
  logic [mavg_pkg::SAMPLE_W-1:0]       quo_low;

  assign trial = {rem_q, dvd_q[mavg_pkg::SUM_W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = '0;
      dvs_d  = divisor_i;
      neg_d  = dividend_i[mavg_pkg::SUM_W-1];
      dvd_d  = dividend_i[mavg_pkg::SUM_W-1] ? (~dividend_i + 1'b1) : dividend_i;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[mavg_pkg::LEN_W-1:0];
        quo_d = {quo_q[mavg_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[mavg_pkg::LEN_W-1:0];
        quo_d = {quo_q[mavg_pkg::SUM_W-2:0], 1'b0};
      end
      dvd_d = {dvd_q[mavg_pkg::SUM_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == mavg_pkg::DIV_CNT_W'(mavg_pkg::SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  // the true quotient always fits the sample range
  assign quo_low    = quo_q[mavg_pkg::SAMPLE_W-1:0];
  assign quotient_o = neg_q ? mavg_pkg::sample_t'(~quo_low + 1'b1)
                            : mavg_pkg::sample_t'(quo_low);
  assign done_o     = done_q;

endmodule

// ----- design/moving_average_min_max_top.sv -----
// Sliding-window moving average with per-sequence min/max of the window averages.
// Samples enter on the slave stream, clamped to -200..200, and the last window_len of
// them are kept in a 1024-entry window memory next to a running sum. For each word the
// departing sample is first read from the window memory, then the sum is updated and
// the new sample written back. Min and max are tracked on window sums; on the word with
// tlast both are divided by window_len in an iterative divider, min first and then max,
// before the result is loaded into the output register. The next sequence may start while
// that result waits on the master stream. A write to window_len (0 reads as 1, above
// 1024 as 1024) starts a fresh sequence; there is no memory clearing pass after reset.
module moving_average_min_max_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mavg_pkg::LEN_W-1:0]       cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [15:0]                      s_axis_tdata,  // [8:0] sample, [15:9] zero
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [23:0]                      m_axis_tdata,  // [8:0] min_avg, [17:9] max_avg
  output logic                             m_axis_tuser   // valid_res
);

  mavg_pkg::state_e               state_q, state_d;
  logic [mavg_pkg::LEN_W-1:0]     wlen_q, wlen_d;
  logic [mavg_pkg::LEN_W-1:0]     len;
  logic [mavg_pkg::PTR_W-1:0]     wp_q, wp_d;
  logic [mavg_pkg::LEN_W-1:0]     fill_q, fill_d;
  mavg_pkg::sum_t                 sum_q, sum_d;
  mavg_pkg::sum_t                 min_sum_q, min_sum_d;
  mavg_pkg::sum_t                 max_sum_q, max_sum_d;
  logic                           any_q, any_d;
  mavg_pkg::sample_t              s_q, s_d;
  logic                           last_q, last_d;
  mavg_pkg::sample_t              res_min_q, res_min_d;
  mavg_pkg::sample_t              res_max_q, res_max_d;
  logic                           m_valid_q, m_valid_d;
  logic [23:0]                    m_data_q, m_data_d;
  logic                           m_user_q, m_user_d;

  mavg_pkg::sample_t              raw;
  mavg_pkg::sample_t              clamped;
  logic                           accept;
  logic                           full_pre;
  logic [mavg_pkg::LEN_W-1:0]     fill_upd;
  mavg_pkg::sum_t                 sum_upd;
  mavg_pkg::sample_t              old_sample;
  logic [mavg_pkg::SAMPLE_W-1:0]  ram_rdata;

  logic                           div_start;
  mavg_pkg::sum_t                 div_dividend;
  logic                           div_done;
  mavg_pkg::sample_t              div_quot;

  // effective window length
  always_comb begin
    if (wlen_q == '0) begin
      len = mavg_pkg::LEN_W'(1);
    end else if (wlen_q > mavg_pkg::LEN_W'(mavg_pkg::MAX_WINDOW)) begin
      len = mavg_pkg::LEN_W'(mavg_pkg::MAX_WINDOW);
    end else begin
      len = wlen_q;
    end
  end

  assign raw = mavg_pkg::sample_t'(s_axis_tdata[mavg_pkg::SAMPLE_W-1:0]);
  always_comb begin
    if (raw < mavg_pkg::TEMP_LOW) begin
      clamped = mavg_pkg::TEMP_LOW;
    end else if (raw > mavg_pkg::TEMP_HIGH) begin
      clamped = mavg_pkg::TEMP_HIGH;
    end else begin
      clamped = raw;
    end
  end

  assign s_axis_tready = (state_q == mavg_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  mavg_ram #(
    .WIDTH (mavg_pkg::SAMPLE_W),
    .DEPTH (mavg_pkg::MAX_WINDOW)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (state_q == mavg_pkg::ST_UPD),
    .waddr_i (wp_q),
    .wdata_i (s_q),
    .re_i    (accept),
    .raddr_i (wp_q - len[mavg_pkg::PTR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign old_sample = mavg_pkg::sample_t'(ram_rdata);
  assign full_pre   = (fill_q >= len);
  assign fill_upd   = full_pre ? fill_q : fill_q + 1'b1;
  assign sum_upd    = sum_q + mavg_pkg::sum_t'(s_q)
                    - (full_pre ? mavg_pkg::sum_t'(old_sample) : '0);

  mavg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (len),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_comb begin
    state_d      = state_q;
    wlen_d       = wlen_q;
    wp_d         = wp_q;
    fill_d       = fill_q;
    sum_d        = sum_q;
    min_sum_d    = min_sum_q;
    max_sum_d    = max_sum_q;
    any_d        = any_q;
    s_d          = s_q;
    last_d       = last_q;
    res_min_d    = res_min_q;
    res_max_d    = res_max_q;
    m_valid_d    = m_valid_q;
    m_data_d     = m_data_q;
    m_user_d     = m_user_q;
    div_start    = 1'b0;
    div_dividend = min_sum_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      mavg_pkg::ST_IDLE: begin
        if (accept) begin
          s_d     = clamped;
          last_d  = s_axis_tlast;
          state_d = mavg_pkg::ST_UPD;
        end
      end
      mavg_pkg::ST_UPD: begin
        sum_d  = sum_upd;
        fill_d = fill_upd;
        wp_d   = wp_q + 1'b1;
        if (fill_upd >= len) begin
          any_d = 1'b1;
          // averages are monotone in the sum: track sums, divide at the end
          if (!any_q || sum_upd < min_sum_q) begin
            min_sum_d = sum_upd;
          end
          if (!any_q || sum_upd > max_sum_q) begin
            max_sum_d = sum_upd;
          end
        end
        if (!last_q) begin
          state_d = mavg_pkg::ST_IDLE;
        end else if (any_d) begin
          div_start    = 1'b1;
          div_dividend = min_sum_d;
          state_d      = mavg_pkg::ST_DIV_MIN;
        end else begin
          state_d = mavg_pkg::ST_DONE;
        end
      end
      mavg_pkg::ST_DIV_MIN: begin
        if (div_done) begin
          res_min_d    = div_quot;
          div_start    = 1'b1;
          div_dividend = max_sum_q;
          state_d      = mavg_pkg::ST_DIV_MAX;
        end
      end
      mavg_pkg::ST_DIV_MAX: begin
        if (div_done) begin
          res_max_d = div_quot;
          state_d   = mavg_pkg::ST_DONE;
        end
      end
      mavg_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_user_d  = any_q;
          m_data_d  = any_q ? {6'b0, res_max_q, res_min_q} : '0;
          wp_d      = '0;
          fill_d    = '0;
          sum_d     = '0;
          any_d     = 1'b0;
          state_d   = mavg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mavg_pkg::ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      wlen_d = cfg_wdata_i;
      wp_d   = '0;
      fill_d = '0;
      sum_d  = '0;
      any_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mavg_pkg::ST_IDLE;
      wlen_q    <= mavg_pkg::LEN_W'(1);
      wp_q      <= '0;
      fill_q    <= '0;
      sum_q     <= '0;
      any_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wlen_q    <= wlen_d;
      wp_q      <= wp_d;
      fill_q    <= fill_d;
      sum_q     <= sum_d;
      any_q     <= any_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_sum_q <= min_sum_d;
    max_sum_q <= max_sum_d;
    s_q       <= s_d;
    last_q    <= last_d;
    res_min_q <= res_min_d;
    res_max_q <= res_max_d;
    m_data_q  <= m_data_d;
    m_user_q  <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= mavg_pkg::LEN_W'(mavg_pkg::MAX_WINDOW))
    else $error("fill count beyond window memory depth");

  a_any_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_q |-> (fill_q >= len))
    else $error("window flagged without a full window");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (any_q && state_q != mavg_pkg::ST_UPD) |-> (min_sum_q <= max_sum_q))
    else $error("min window sum above max window sum");

  a_accept_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_we_i) |=> (state_q == mavg_pkg::ST_UPD))
    else $error("accepted word did not advance to update");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the moving average min/max block with a scoreboard class.
`timescale 1ns / 1ps

module tb_top;

  localparam int WIN_DEPTH     = mavg_pkg::MAX_WINDOW;
  localparam int ITEM_TARGET   = 950;
  localparam int TAIL_WORDS    = 20;
  localparam int NOIDLE_FROM   = 300;
  localparam int NOIDLE_TO     = 500;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_PCT      = 17;

  typedef struct packed {
    mavg_pkg::sample_t min_avg;
    mavg_pkg::sample_t max_avg;
    logic              valid;
  } avg_result_t;

  class mavg_scoreboard;
    mavg_pkg::sample_t hist [WIN_DEPTH];
    int                wr_ptr;
    int                fill;
    int                run_sum;
    int                lo_avg;
    int                hi_avg;
    bit                any_full;
    int                span;
    avg_result_t       awaited_q [$];
    int                errors;
    int                checked;

    function new();
      span    = 1;
      errors  = 0;
      checked = 0;
      clear_run();
    endfunction

    function void clear_run();
      wr_ptr   = 0;
      fill     = 0;
      run_sum  = 0;
      lo_avg   = mavg_pkg::TEMP_HIGH;
      hi_avg   = mavg_pkg::TEMP_LOW;
      any_full = 1'b0;
    endfunction

    // A length write also starts a fresh sequence.
    function void load_len(input logic [mavg_pkg::LEN_W-1:0] v);
      if (v == 0) span = 1;
      else if (v > WIN_DEPTH) span = WIN_DEPTH;
      else span = int'(v);
      clear_run();
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction

    function void note_input(input logic [mavg_pkg::SAMPLE_W-1:0] raw, input bit is_last);
      int          s;
      int          avg;
      avg_result_t r;
      s = $signed(raw);
      if (s < mavg_pkg::TEMP_LOW) s = mavg_pkg::TEMP_LOW;
      if (s > mavg_pkg::TEMP_HIGH) s = mavg_pkg::TEMP_HIGH;
      // drop the sample leaving the window
      if (fill >= span) run_sum -= hist[(wr_ptr + WIN_DEPTH - span) % WIN_DEPTH];
      hist[wr_ptr] = mavg_pkg::sample_t'(s);
      run_sum += s;
      wr_ptr = (wr_ptr + 1) % WIN_DEPTH;
      if (fill < span) fill++;
      if (fill >= span) begin
        avg = run_sum / span;
        if (avg < lo_avg) lo_avg = avg;
        if (avg > hi_avg) hi_avg = avg;
        any_full = 1'b1;
      end
      if (is_last) begin
        r.min_avg = any_full ? mavg_pkg::sample_t'(lo_avg) : '0;
        r.max_avg = any_full ? mavg_pkg::sample_t'(hi_avg) : '0;
        r.valid   = any_full;
        awaited_q.push_back(r);
        clear_run();
      end
    endfunction

    function void check_result(input logic [23:0] data, input logic user);
      avg_result_t       want;
      mavg_pkg::sample_t got_min;
      mavg_pkg::sample_t got_max;
      got_min = data[8:0];
      got_max = data[17:9];
      if (awaited_q.size() == 0) begin
        $display("%0t: result min %0d max %0d valid %0b arrived with none expected",
                 $time, got_min, got_max, user);
        errors++;
        return;
      end
      want = awaited_q.pop_front();
      checked++;
      if (got_min !== want.min_avg) begin
        $display("%0t: min_avg expected %0d, actual %0d", $time, want.min_avg, got_min);
        errors++;
      end
      if (got_max !== want.max_avg) begin
        $display("%0t: max_avg expected %0d, actual %0d", $time, want.max_avg, got_max);
        errors++;
      end
      if (user !== want.valid) begin
        $display("%0t: valid_res expected %0b, actual %0b", $time, want.valid, user);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [mavg_pkg::LEN_W-1:0] cfg_wdata_i;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [15:0]                s_axis_tdata;
  logic                       s_axis_tlast;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [23:0]                m_axis_tdata;
  logic                       m_axis_tuser;

  mavg_scoreboard sb = new();
  bit             no_idle      = 1'b0;
  bit             hold_pending = 1'b0;
  int             words_sent   = 0;
  int             len_writes   = 0;

  moving_average_min_max_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    #1_000_000;
    $display("Run timed out");
    $display("Mismatches found");
    $finish;
  end

  // Result side: random back-pressure plus one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        m_axis_tready <= 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clk_i);
        hold_pending = 1'b0;
      end
      m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Offer one word and hold it until it is taken.
  task automatic send_word(input int value, input bit is_last);
    // run a stretch of words with no idling on either side
    no_idle = (words_sent >= NOIDLE_FROM && words_sent < NOIDLE_TO);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, value[mavg_pkg::SAMPLE_W-1:0]};
    s_axis_tlast  <= is_last;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_input(value[mavg_pkg::SAMPLE_W-1:0], is_last);
    words_sent++;
  endtask

  // Drain everything, let the block settle, then return with the input idle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_len(input int v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[mavg_pkg::LEN_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.load_len(v[mavg_pkg::LEN_W-1:0]);
    len_writes++;
  endtask

  // kind 1 leans on the upper clamp, kind 2 on the lower, kind 0 is mixed
  function automatic int pick_sample(input int kind);
    int r;
    r = $urandom_range(99);
    if (kind == 1) return (r < 80) ? 200 : int'($urandom_range(201, 255));
    if (kind == 2) return (r < 80) ? -200 : -int'($urandom_range(201, 256));
    if (r < 12) return int'($urandom_range(511));
    if (r < 18) return (r < 15) ? 200 : -200;
    return int'($urandom_range(400)) - 200;
  endfunction

  task automatic run_seq(input int n, input int kind);
    for (int i = 0; i < n; i++) send_word(pick_sample(kind), i == n - 1);
  endtask

  initial begin
    int phase;
    int len;
    int eff;
    int nseq;
    int n;
    int kind;
    int r;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset length of one: extremes and clamping on both sides.
    send_word(200, 0);
    send_word(-200, 0);
    send_word(255, 0);
    send_word(-256, 0);
    send_word(0, 0);
    send_word(-1, 1);
    // Zero length acts as one.
    write_len(0);
    send_word(201, 0);
    send_word(-201, 0);
    send_word(7, 1);
    // Sequence shorter than the window, then a lone last word.
    write_len(3);
    send_word(5, 0);
    send_word(6, 1);
    send_word(9, 1);
    // Negative averages truncate toward zero.
    send_word(-7, 0);
    send_word(-8, 0);
    send_word(-10, 0);
    send_word(100, 1);
    // Last word completes the first full window.
    write_len(2);
    send_word(3, 0);
    send_word(4, 1);
    send_word(-3, 0);
    send_word(-4, 1);

    phase = 0;
    while (words_sent < ITEM_TARGET - TAIL_WORDS) begin
      phase++;
      r = $urandom_range(99);
      if (r < 8) len = 0;
      else if (r < 16) len = 1;
      else if (r < 70) len = $urandom_range(2, 8);
      else if (r < 90) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 120);
      if (phase == 1) len = 2;
      write_len(len);
      eff = (len == 0) ? 1 : len;
      if (phase == 1) begin
        // Hold the result side off while short sequences pile up.
        hold_pending = 1'b1;
        for (int k = 0; k < 8; k++) run_seq($urandom_range(1, 4), 0);
      end else begin
        nseq = $urandom_range(2, 6);
        for (int k = 0; k < nseq; k++) begin
          if (words_sent >= ITEM_TARGET - TAIL_WORDS) break;
          r = $urandom_range(99);
          kind = (r < 10) ? 1 : (r < 20) ? 2 : 0;
          if ($urandom_range(99) < 80) n = eff + $urandom_range(0, 2 * eff + 3);
          else n = $urandom_range(1, eff);
          // keep the word count near its target
          if (n > ITEM_TARGET - TAIL_WORDS - words_sent)
            n = ITEM_TARGET - TAIL_WORDS - words_sent;
          run_seq(n, kind);
        end
        // Leave an unfinished sequence for the next length write to discard.
        if ($urandom_range(99) < 10) begin
          n = $urandom_range(1, 3);
          for (int k = 0; k < n; k++) send_word(pick_sample(0), 0);
        end
      end
    end

    // Top length codes: the largest window and a saturated one, both left unfilled.
    write_len(1024);
    run_seq(TAIL_WORDS / 2, 0);
    write_len(2047);
    run_seq(TAIL_WORDS / 2, 1);

    drain();
    $display("Sent %0d words across %0d window lengths, including the top length codes;",
             words_sent, len_writes + 1);
    $display("%0d sequence results compared, with clamping and back-pressure exercised.",
             sb.checked);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
